@@ hw/rtl/usa_pkg.sv @@
// Shared types and constants for the upwind scalar advection cell.
// Used by usa_axis, upwind_scalar_advection_cell and tb_top; no dependencies.
package usa_pkg;

  localparam int unsigned DW        = 48;  // scalar and momentum width
  localparam int unsigned DT_W      = 32;  // time step over spacing width
  localparam int unsigned DT_FRAC   = 24;  // fraction bits of the time step
  localparam int unsigned QW        = 103; // quotient width after the time step shift
  localparam int unsigned TERM_W    = QW + 1;
  localparam int unsigned SUM_W     = 106;
  localparam int unsigned DIV_STEPS = QW;
  localparam int unsigned LANE_LAT  = DIV_STEPS + 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ON = 3'd4;

  typedef struct packed {
    logic signed [DW-1:0] density;
    logic signed [DW-1:0] mom_x;
    logic signed [DW-1:0] mom_y;
    logic signed [DW-1:0] mom_z;
    logic signed [DW-1:0] scal_c;
    logic signed [DW-1:0] scal_xm;
    logic signed [DW-1:0] scal_xp;
    logic signed [DW-1:0] scal_ym;
    logic signed [DW-1:0] scal_yp;
    logic signed [DW-1:0] scal_zm;
    logic signed [DW-1:0] scal_zp;
  } usa_in_t;

  typedef struct packed {
    logic signed [DW-1:0] scal_new;
    logic                 fault;
    logic                 saturated;
  } usa_out_t;

endpackage

@@ hw/rtl/usa_axis.sv @@
// One axis term of the upwind update: trunc(dt * mom * diff / (rho * 2^24)).
// Split multiplies followed by a restoring divider, one quotient bit per stage.
// Depends on usa_pkg.
module usa_axis import usa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  logic signed [DW-1:0]    mom,
  input  logic signed [DW-1:0]    c,
  input  logic signed [DW-1:0]    m,
  input  logic signed [DW-1:0]    p,
  input  logic [DT_W-1:0]         dt,
  input  logic [DW-2:0]           rho,
  output logic                    v_out,
  output logic signed [TERM_W-1:0] term
);

  // Stage 1: upwind difference and magnitudes.
  logic            v1_r;
  logic [DW-1:0]   mm1_r, dm1_r;
  logic            neg1_r;
  logic [DT_W-1:0] dt1_r;
  logic [DW-2:0]   den1_r;
  // Stage 2: four 24x24 partial products.
  logic            v2_r;
  logic [DW-1:0]   pp2_r [4];
  logic            neg2_r;
  logic [DT_W-1:0] dt2_r;
  logic [DW-2:0]   den2_r;
  // Stage 3: |mom| * |diff|.
  logic            v3_r;
  logic [2*DW-1:0] prod3_r;
  logic            neg3_r;
  logic [DT_W-1:0] dt3_r;
  logic [DW-2:0]   den3_r;
  // Stage 4: four 24x32 partial products with the time step.
  logic            v4_r;
  logic [DT_W+23:0] pq4_r [4];
  logic            neg4_r;
  logic [DW-2:0]   den4_r;
  // Divider stages.
  logic            dv_r   [DIV_STEPS+1];
  logic [QW-1:0]   num_r  [DIV_STEPS+1];
  logic [DW-2:0]   rem_r  [DIV_STEPS+1];
  logic            dneg_r [DIV_STEPS+1];
  logic [DW-2:0]   dden_r [DIV_STEPS+1];
  // Output stage.
  logic                    vo_r;
  logic signed [TERM_W-1:0] term_r;

  logic signed [DW:0] diff;
  logic [DW-1:0]      mm_nxt, dm_nxt;
  logic               mom_pos;
  logic [127:0]       full_nxt;
  logic [DW-1:0]      r2     [DIV_STEPS];
  logic               ge     [DIV_STEPS];
  logic [DW-2:0]      rem_nxt[DIV_STEPS];

  always_comb begin
    mom_pos = !mom[DW-1] && (mom != '0);
    diff    = mom_pos ? ($signed({c[DW-1], c}) - $signed({m[DW-1], m}))
                      : ($signed({p[DW-1], p}) - $signed({c[DW-1], c}));
    mm_nxt  = mom[DW-1] ? DW'(-{1'b0, mom}) : DW'(mom);
    dm_nxt  = diff[DW] ? DW'(-diff) : DW'(diff);
    full_nxt = {72'd0, pq4_r[0]}
             + {48'd0, pq4_r[1], 24'd0}
             + {24'd0, pq4_r[2], 48'd0}
             + {pq4_r[3], 72'd0};
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2[k]      = {rem_r[k], num_r[k][QW-1]};
      ge[k]      = r2[k] >= {1'b0, dden_r[k]};
      rem_nxt[k] = ge[k] ? (DW-1)'(r2[k] - {1'b0, dden_r[k]}) : r2[k][DW-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r[0] <= v4_r;
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k+1] <= dv_r[k];
      vo_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm1_r  <= mm_nxt;
      dm1_r  <= dm_nxt;
      neg1_r <= mom[DW-1] != diff[DW];
      dt1_r  <= dt;
      den1_r <= rho;

      pp2_r[0] <= mm1_r[23:0]  * dm1_r[23:0];
      pp2_r[1] <= mm1_r[47:24] * dm1_r[23:0];
      pp2_r[2] <= mm1_r[23:0]  * dm1_r[47:24];
      pp2_r[3] <= mm1_r[47:24] * dm1_r[47:24];
      neg2_r   <= neg1_r;
      dt2_r    <= dt1_r;
      den2_r   <= den1_r;

      prod3_r <= {48'd0, pp2_r[0]} + {24'd0, pp2_r[1], 24'd0}
               + {24'd0, pp2_r[2], 24'd0} + {pp2_r[3], 48'd0};
      neg3_r  <= neg2_r;
      dt3_r   <= dt2_r;
      den3_r  <= den2_r;

      for (int i = 0; i < 4; i++) pq4_r[i] <= prod3_r[24*i +: 24] * dt3_r;
      neg4_r <= neg3_r;
      den4_r <= den3_r;

      // The product is below 2^127; dropping the time step fraction first
      // gives the same floor as dividing first.
      num_r[0]  <= full_nxt[DT_FRAC +: QW];
      rem_r[0]  <= '0;
      dneg_r[0] <= neg4_r;
      dden_r[0] <= den4_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        num_r[k+1]  <= {num_r[k][QW-2:0], ge[k]};
        rem_r[k+1]  <= rem_nxt[k];
        dneg_r[k+1] <= dneg_r[k];
        dden_r[k+1] <= dden_r[k];
      end

      term_r <= dneg_r[DIV_STEPS] ? -$signed({1'b0, num_r[DIV_STEPS]})
                                  :  $signed({1'b0, num_r[DIV_STEPS]});
    end
  end

  assign v_out = vo_r;
  assign term  = term_r;

endmodule

@@ hw/rtl/upwind_scalar_advection_cell.sv @@
// Throughput: one item per cycle while the pipeline advances, which it does
// whenever the output is free; the 103-stage divider in each axis lane sets
// the depth.
// Reset (synchronous, rst_n low) empties the pipeline and sets the time step
// registers to zero and both axis enables to one.
module upwind_scalar_advection_cell import usa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  usa_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output usa_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DT_W-1:0]      cfg_data
);

  logic [DT_W-1:0] dtx_r, dty_r, dtz_r;
  logic            yon_r, zon_r;
  logic            en;

  logic                     vx, vy, vz;
  logic signed [TERM_W-1:0] tx, ty, tz;

  logic              dc_fault_r [LANE_LAT];
  logic signed [DW-1:0] dc_c_r  [LANE_LAT];

  logic                    sv_r, sf_r;
  logic signed [DW-1:0]    sc_r;
  logic signed [SUM_W-1:0] sum_r;

  logic      out_valid_r;
  usa_out_t  out_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtx_r <= '0;
      dty_r <= '0;
      dtz_r <= '0;
      yon_r <= 1'b1;
      zon_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DT_X: dtx_r <= cfg_data;
        REG_DT_Y: dty_r <= cfg_data;
        REG_DT_Z: dtz_r <= cfg_data;
        REG_Y_ON: yon_r <= cfg_data[0];
        REG_Z_ON: zon_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  usa_axis u_ax (
    .clk, .rst_n, .en, .v_in(in_valid),
    .mom(in_data.mom_x), .c(in_data.scal_c), .m(in_data.scal_xm), .p(in_data.scal_xp),
    .dt(dtx_r), .rho(in_data.density[DW-2:0]), .v_out(vx), .term(tx)
  );

  usa_axis u_ay (
    .clk, .rst_n, .en, .v_in(in_valid),
    .mom(in_data.mom_y), .c(in_data.scal_c), .m(in_data.scal_ym), .p(in_data.scal_yp),
    .dt(yon_r ? dty_r : '0), .rho(in_data.density[DW-2:0]), .v_out(vy), .term(ty)
  );

  usa_axis u_az (
    .clk, .rst_n, .en, .v_in(in_valid),
    .mom(in_data.mom_z), .c(in_data.scal_c), .m(in_data.scal_zm), .p(in_data.scal_zp),
    .dt(zon_r ? dtz_r : '0), .rho(in_data.density[DW-2:0]), .v_out(vz), .term(tz)
  );

  // Cell scalar and fault flag ride alongside the lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      dc_c_r[0]     <= in_data.scal_c;
      dc_fault_r[0] <= in_data.density[DW-1] || (in_data.density == '0);
      for (int k = 1; k < LANE_LAT; k++) begin
        dc_c_r[k]     <= dc_c_r[k-1];
        dc_fault_r[k] <= dc_fault_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sv_r        <= vx;
      out_valid_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r  <= dc_c_r[LANE_LAT-1];
      sf_r  <= dc_fault_r[LANE_LAT-1];
      sum_r <= SUM_W'(dc_c_r[LANE_LAT-1]) - SUM_W'(tx) - SUM_W'(ty) - SUM_W'(tz);
      if (sf_r) begin
        out_r.scal_new  <= sc_r;
        out_r.fault     <= 1'b1;
        out_r.saturated <= 1'b0;
      end else if (sum_r[SUM_W-1:DW-1] == '0 || sum_r[SUM_W-1:DW-1] == '1) begin
        out_r.scal_new  <= sum_r[DW-1:0];
        out_r.fault     <= 1'b0;
        out_r.saturated <= 1'b0;
      end else begin
        out_r.scal_new  <= sum_r[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        out_r.fault     <= 1'b0;
        out_r.saturated <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fault_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fault |-> !out_r.saturated)
    else $error("fault and saturated both set");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (vx == vy) && (vy == vz))
    else $error("axis lanes out of step");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for upwind_scalar_advection_cell.
// Depends on usa_pkg; predicts each cell update with wide integer arithmetic
// and checks results in order under random idling on both channels.
module tb_top;
  import usa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_TAIL  = LANE_LAT + 40;
  localparam int WDOG_LIMIT = 4000;

  typedef logic signed [139:0] wide_t;

  class advection_scoreboard;
    logic [DT_W-1:0] dt_x, dt_y, dt_z;
    logic            y_on, z_on;
    usa_out_t        expected_q[$];
    int              mismatches;

    function new();
      dt_x = '0; dt_y = '0; dt_z = '0;
      y_on = 1'b1; z_on = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DT_W-1:0] val);
      case (idx)
        REG_DT_X: dt_x = val;
        REG_DT_Y: dt_y = val;
        REG_DT_Z: dt_z = val;
        REG_Y_ON: y_on = val[0];
        REG_Z_ON: z_on = val[0];
        default: ;
      endcase
    endfunction

    // One axis contribution: dt * mom * diff / (rho * 2^24), truncated toward zero.
    function wide_t flux_term(logic signed [DW-1:0] mom, logic signed [DW-1:0] c,
                              logic signed [DW-1:0] m, logic signed [DW-1:0] p,
                              logic [DT_W-1:0] dt, logic [DW-1:0] rho);
      logic signed [49:0] diff, smom;
      logic [49:0]        mag_m, mag_d;
      logic [139:0]       quot;
      logic               neg;
      diff = (mom > 0) ? (c - m) : (p - c);
      smom = mom;
      if (mom == 0 || diff == 0 || dt == 0) return '0;
      neg   = (smom < 0) != (diff < 0);
      mag_m = (smom < 0) ? -smom : smom;
      mag_d = (diff < 0) ? -diff : diff;
      quot  = ({90'd0, mag_m} * {90'd0, mag_d} * {108'd0, dt}) / {92'd0, rho};
      quot  = quot >> DT_FRAC;
      return neg ? -$signed(quot) : $signed(quot);
    endfunction

    function usa_out_t predict_cell(usa_in_t x);
      usa_out_t r;
      wide_t    sum, res;
      wide_t    hi_lim, lo_lim;
      hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
      lo_lim = -(wide_t'(1) <<< (DW - 1));
      r.fault = 1'b0;
      r.saturated = 1'b0;
      if (x.density <= 0) begin
        r.scal_new = x.scal_c;
        r.fault = 1'b1;
        return r;
      end
      sum = flux_term(x.mom_x, x.scal_c, x.scal_xm, x.scal_xp, dt_x, x.density);
      if (y_on) sum = sum + flux_term(x.mom_y, x.scal_c, x.scal_ym, x.scal_yp, dt_y, x.density);
      if (z_on) sum = sum + flux_term(x.mom_z, x.scal_c, x.scal_zm, x.scal_zp, dt_z, x.density);
      res = wide_t'(x.scal_c) - sum;
      if (res > hi_lim) begin
        r.scal_new = hi_lim[DW-1:0];
        r.saturated = 1'b1;
      end else if (res < lo_lim) begin
        r.scal_new = lo_lim[DW-1:0];
        r.saturated = 1'b1;
      end else begin
        r.scal_new = res[DW-1:0];
      end
      return r;
    endfunction

    function void note_cell(usa_in_t x);
      expected_q.push_back(predict_cell(x));
    endfunction

    function void check_cell(usa_out_t got);
      usa_out_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.scal_new !== exp_r.scal_new || got.fault !== exp_r.fault ||
          got.saturated !== exp_r.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected scal_new=%h fault=%b sat=%b, got scal_new=%h fault=%b sat=%b",
                   exp_r.scal_new, exp_r.fault, exp_r.saturated,
                   got.scal_new, got.fault, got.saturated);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  usa_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  usa_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DT_W-1:0] cfg_data = '0;

  advection_scoreboard sb = new();
  bit idle_on = 1'b1;
  int quiet_cycles = 0;

  upwind_scalar_advection_cell i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check every accepted item, then draw a fresh stall length.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_cell(out_data);
      stall_left = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_n && quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    // Idling here keeps the drop of valid apart from the next write.
    @(posedge clk);
  endtask

  task automatic send_cell(usa_in_t x);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    sb.note_cell(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return DW'($signed($urandom_range(0, 4)) - 2);
      3: return DW'($signed({$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'(r[30:0])}));
      4: return DW'(r[29:0]) << $urandom_range(0, 17);
      default: return r[DW-1:0];
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_density();
    case ($urandom_range(0, 9))
      0: return rand_val();
      1: return DW'($urandom_range(1, 255));
      2: return {1'b0, {(DW-1){1'b1}}};
      default: return DW'($urandom_range(1, 1 << 30)) << $urandom_range(0, 16);
    endcase
  endfunction

  function automatic usa_in_t rand_cell();
    usa_in_t x;
    logic [DW-1:0] c;
    c = rand_val();
    x.density = rand_density();
    x.mom_x = rand_val();
    x.mom_y = rand_val();
    x.mom_z = rand_val();
    x.scal_c = c;
    // Neighbors mostly sit near the center, as in a smooth field.
    x.scal_xm = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    x.scal_xp = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    x.scal_ym = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    x.scal_yp = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    x.scal_zm = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    x.scal_zp = $urandom_range(0, 2) ? c + DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rand_val();
    return x;
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DT_W'(1) << DT_FRAC;
      3: return DT_W'($urandom_range(0, 1 << 26));
      default: return $urandom;
    endcase
  endfunction

  localparam logic [DW-1:0] MAX48 = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN48 = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE   = DW'(1) << 24;

  initial begin
    usa_in_t x;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cells under unit time steps with all axes on.
    write_cfg(REG_DT_X, DT_W'(1) << DT_FRAC);
    write_cfg(REG_DT_Y, DT_W'(1) << DT_FRAC);
    write_cfg(REG_DT_Z, DT_W'(1) << DT_FRAC);
    write_cfg(REG_Y_ON, 32'd1);
    write_cfg(REG_Z_ON, 32'd1);
    write_cfg(3'd7, '1);
    x = '{ONE, ONE, -ONE, '0, ONE, '0, 2 * ONE, '0, 3 * ONE, ONE, ONE};
    send_cell(x);
    x.density = '0;  send_cell(x);      // zero density faults
    x.density = '1;  send_cell(x);      // negative density faults
    x.density = MIN48; send_cell(x);
    x.density = 48'd1; send_cell(x);    // tiny density, huge velocity
    x = '{48'd1, MAX48, MIN48, MAX48, MAX48, MIN48, MIN48, MAX48, MIN48, MIN48, MAX48};
    send_cell(x);                       // clips high or low
    x = '{48'd1, MIN48, MAX48, MIN48, MIN48, MAX48, MAX48, MIN48, MAX48, MAX48, MIN48};
    send_cell(x);
    x = '{MAX48, MAX48, MAX48, MAX48, '0, MAX48, MIN48, MIN48, MAX48, MAX48, MIN48};
    send_cell(x);
    x = '{ONE, '0, '0, '0, ONE, MAX48, MIN48, MAX48, MIN48, MAX48, MIN48};
    send_cell(x);                       // zero momenta contribute nothing
    drain();

    // Axis enables off and extreme time steps.
    write_cfg(REG_DT_X, '1);
    write_cfg(REG_DT_Y, '1);
    write_cfg(REG_DT_Z, '0);
    write_cfg(REG_Y_ON, 32'd0);
    write_cfg(REG_Z_ON, 32'd0);
    x = '{ONE, ONE, MAX48, MIN48, '0, MIN48, MAX48, MIN48, MAX48, MIN48, MAX48};
    send_cell(x);
    x = '{48'd3, MIN48, MAX48, MAX48, MAX48, MIN48, MAX48, MIN48, MAX48, MIN48, MAX48};
    send_cell(x);
    drain();

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase % 3) != 2;
      write_cfg(REG_DT_X, rand_dt());
      write_cfg(REG_DT_Y, rand_dt());
      write_cfg(REG_DT_Z, rand_dt());
      write_cfg(REG_Y_ON, $urandom);
      write_cfg(REG_Z_ON, $urandom);
      if ($urandom_range(0, 1)) write_cfg(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
      repeat (125) send_cell(rand_cell());
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/usa_pkg.sv
hw/rtl/usa_axis.sv
hw/rtl/upwind_scalar_advection_cell.sv
test/tb_top.sv
